// File: design/wdft_pkg.sv
// Shared widths, Q2.30 constants and record types for the windowed DFT frame block.
// No dependencies; windowed_dft_frame imports this package.
package wdft_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int OUT_W              = 24;
    localparam int BIN_W              = 6;
    localparam int DEF_FRAME_LEN      = 64;
    localparam int DEF_COEF_FRAC_BITS = 15;

    // Fixed-point constants used when the coefficient tables are built.
    localparam int Q30_FRAC = 30;
    localparam logic [63:0] PI_Q30 =
        (64'd31415926 * 64'd1073741824 + 64'd5000000) / 64'd10000000;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 <<< Q30_FRAC;

    // Eight-term Taylor series: divisors (2k-1)(2k) for cosine and (2k)(2k+1) for sine.
    localparam int TAYLOR_TERMS = 8;
    localparam int unsigned COS_DIV [TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240};
    localparam int unsigned SIN_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } trig_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] bin_real;
        logic signed [OUT_W-1:0] bin_imag;
        logic [BIN_W-1:0]        bin_index;
        logic                    last_bin;
    } result_t;

endpackage

// File: design/windowed_dft_frame.sv
// Windowed direct DFT over frames of FRAME_LEN samples; uses wdft_pkg.
// Takes one sample per cycle while a frame fills. With the Hamming window the store is then
// windowed in place; each bin then reads the whole frame through the single read port of
// the sample memory, and the last read of a bin waits while no output slot is free.
// The input stays closed until every bin of the frame has been issued. Reset sets control
// and window_type (Hamming), not the memory.
module windowed_dft_frame #(
    parameter int FRAME_LEN      = wdft_pkg::DEF_FRAME_LEN,
    parameter int COEF_FRAC_BITS = wdft_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wdft_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wdft_pkg::OUT_W-1:0]   m_bin_real,
    output logic signed [wdft_pkg::OUT_W-1:0]   m_bin_imag,
    output logic [wdft_pkg::BIN_W-1:0]          m_bin_index,
    output logic                                m_last_bin,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_window_type
);

    import wdft_pkg::*;

    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int COEF_W     = COEF_FRAC_BITS + 1;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + IDX_W;
    localparam int WIN_DEN    = FRAME_LEN - 1;
    localparam int Q30_SH     = Q30_FRAC - COEF_FRAC_BITS;
    localparam int FIFO_DEPTH = 2;

    localparam logic signed [63:0] Q30_HALF = 64'sd1 <<< (Q30_SH - 1);
    localparam logic signed [63:0] COEF_MAX = (64'sd1 <<< COEF_FRAC_BITS) - 64'sd1;
    localparam logic signed [63:0] COEF_MIN = -(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W:0]   IDX_WRAP  = (IDX_W + 1)'(FRAME_LEN);
    localparam logic [1:0]       FIFO_FULL = 2'(FIFO_DEPTH);

    typedef logic signed [COEF_W-1:0] coef_tab_t [FRAME_LEN];
    typedef enum logic [1:0] {TAB_COS, TAB_SIN, TAB_WIN} tab_kind_t;

    // Cosine and sine of 2*pi*num/den in Q2.30, den being FRAME_LEN or FRAME_LEN-1.
    function automatic trig_t trig_q30(input int unsigned num, input logic win_den);
        logic [63:0]        n;
        logic [63:0]        quad;
        logic [63:0]        rem;
        logic [63:0]        x;
        logic [63:0]        tc;
        logic [63:0]        ts;
        logic signed [63:0] sc;
        logic signed [63:0] ss;
        trig_t              r;
        if (win_den) begin
            n    = 64'(num) % WIN_DEN;
            quad = (64'd4 * n) / WIN_DEN;
            rem  = 64'd4 * n - quad * WIN_DEN;
            x    = (PI_Q30 * rem) / (2 * WIN_DEN);
        end else begin
            n    = 64'(num) % FRAME_LEN;
            quad = (64'd4 * n) / FRAME_LEN;
            rem  = 64'd4 * n - quad * FRAME_LEN;
            x    = (PI_Q30 * rem) / (2 * FRAME_LEN);
        end
        tc = 64'(ONE_Q30);
        ts = x;
        sc = ONE_Q30;
        ss = signed'(x);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            tc = ((((tc * x) >> Q30_FRAC) * x) >> Q30_FRAC) / COS_DIV[k-1];
            ts = ((((ts * x) >> Q30_FRAC) * x) >> Q30_FRAC) / SIN_DIV[k-1];
            if ((k & 1) != 0) begin
                sc = sc - signed'(tc);
                ss = ss - signed'(ts);
            end else begin
                sc = sc + signed'(tc);
                ss = ss + signed'(ts);
            end
        end
        case (quad[1:0])
            2'd0: begin
                r.c = sc;
                r.s = ss;
            end
            2'd1: begin
                r.c = -ss;
                r.s = sc;
            end
            2'd2: begin
                r.c = -sc;
                r.s = -ss;
            end
            default: begin
                r.c = ss;
                r.s = -sc;
            end
        endcase
        return r;
    endfunction

    // Round half up from Q2.30 to Q1.F and saturate, so that 1.0 becomes 2^F-1.
    function automatic logic signed [COEF_W-1:0] q30_to_coef(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + Q30_HALF) >>> Q30_SH;
        if (r > COEF_MAX) begin
            r = COEF_MAX;
        end
        if (r < COEF_MIN) begin
            r = COEF_MIN;
        end
        return r[COEF_W-1:0];
    endfunction

    function automatic coef_tab_t build_tab(input tab_kind_t kind);
        coef_tab_t          tab;
        trig_t              t;
        logic signed [63:0] w;
        for (int m = 0; m < FRAME_LEN; m++) begin
            case (kind)
                TAB_COS: begin
                    t = trig_q30(m, 1'b0);
                    tab[m] = q30_to_coef(t.c);
                end
                TAB_SIN: begin
                    t = trig_q30(m, 1'b0);
                    tab[m] = q30_to_coef(t.s);
                end
                default: begin
                    t = trig_q30(m, 1'b1);
                    w = (64'sd54 * ONE_Q30 - 64'sd46 * t.c + 64'sd50) / 64'sd100;
                    tab[m] = q30_to_coef(w);
                end
            endcase
        end
        return tab;
    endfunction

    localparam coef_tab_t COS_TAB = build_tab(TAB_COS);
    localparam coef_tab_t SIN_TAB = build_tab(TAB_SIN);
    localparam coef_tab_t WIN_TAB = build_tab(TAB_WIN);

    typedef enum logic [1:0] {ST_FILL, ST_WIN, ST_WDRAIN, ST_DFT} state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] m_reg, m_next;
    logic [IDX_W:0]   m_sum;
    logic             window_type_reg;
    logic [1:0]       out_cnt_reg;
    logic [1:0]       fifo_cnt_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;

    logic             fill_we, fill_last, k_last;
    logic             win_issue, dft_issue, res_issue, res_pop;

    // Sample memory: one write port, one registered read port.
    logic signed [SAMPLE_W-1:0] sample_mem [FRAME_LEN];
    logic signed [SAMPLE_W-1:0] mem_rdata_reg;
    logic                       wb_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic signed [PROD_W-1:0]   wb_round;

    // Pipeline: issue, read/coefficient, multiply, accumulate or write back, round.
    logic                     p1_valid_reg, p2_valid_reg, p3_push_reg;
    logic                     p1_win_reg, p1_first_reg, p1_last_reg;
    logic                     p2_win_reg, p2_first_reg, p2_last_reg;
    logic [IDX_W-1:0]         p1_addr_reg, p2_addr_reg;
    logic [IDX_W-1:0]         p1_bin_reg, p2_bin_reg, p3_bin_reg;
    logic signed [COEF_W-1:0] coef_a, coef_a_reg, coef_b_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]  re_round, im_round;
    result_t                  res_word;
    result_t                  fifo_reg [FIFO_DEPTH];

    assign s_ready   = (state_reg == ST_FILL);
    assign cfg_ready = 1'b1;
    assign fill_we   = s_valid && s_ready;
    assign fill_last = (fill_cnt_reg == IDX_LAST);
    assign k_last    = (k_reg == IDX_LAST);

    // The last product of a bin is held back until the result has a guaranteed slot.
    assign win_issue = (state_reg == ST_WIN);
    assign dft_issue = (state_reg == ST_DFT) && !(k_last && out_cnt_reg == FIFO_FULL);
    assign res_issue = dft_issue && k_last;
    assign res_pop   = m_valid && m_ready;

    assign m_sum = {1'b0, m_reg} + {1'b0, j_reg};

    always_comb begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        m_next        = m_reg;
        case (state_reg)
            ST_FILL: begin
                if (fill_we) begin
                    if (fill_last) begin
                        fill_cnt_next = '0;
                        k_next        = '0;
                        j_next        = '0;
                        m_next        = '0;
                        state_next    = window_type_reg ? ST_WIN : ST_DFT;
                    end else begin
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                    end
                end
            end
            ST_WIN: begin
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_WDRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WDRAIN: begin
                // Wait until every windowed sample has been written back.
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = ST_DFT;
                end
            end
            ST_DFT: begin
                if (dft_issue) begin
                    if (k_last) begin
                        k_next = '0;
                        m_next = '0;
                        if (j_reg == IDX_LAST) begin
                            j_next     = '0;
                            state_next = ST_FILL;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                        // Twiddle index (j*k) mod FRAME_LEN advances by j each step.
                        m_next = (m_sum >= IDX_WRAP) ? IDX_W'(m_sum - IDX_WRAP) : IDX_W'(m_sum);
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_FILL;
            fill_cnt_reg    <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            m_reg           <= '0;
            window_type_reg <= 1'b1;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_push_reg     <= 1'b0;
            out_cnt_reg     <= '0;
            fifo_cnt_reg    <= '0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            m_reg        <= m_next;
            if (cfg_valid && cfg_ready) begin
                window_type_reg <= cfg_window_type;
            end
            p1_valid_reg <= win_issue || dft_issue;
            p2_valid_reg <= p1_valid_reg;
            p3_push_reg  <= p2_valid_reg && !p2_win_reg && p2_last_reg;
            out_cnt_reg  <= out_cnt_reg + 2'(res_issue) - 2'(res_pop);
            fifo_cnt_reg <= fifo_cnt_reg + 2'(p3_push_reg) - 2'(res_pop);
            if (p3_push_reg) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (res_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    assign coef_a   = win_issue ? WIN_TAB[k_reg] : COS_TAB[m_reg];
    assign wb_we    = p2_valid_reg && p2_win_reg;
    assign wb_round = (prod_a_reg + PROD_HALF) >>> COEF_FRAC_BITS;
    assign mem_waddr = wb_we ? p2_addr_reg : fill_cnt_reg;
    assign mem_wdata = wb_we ? wb_round[SAMPLE_W-1:0] : s_sample;

    assign re_round = (acc_re_reg + ACC_HALF) >>> COEF_FRAC_BITS;
    assign im_round = (acc_im_reg + ACC_HALF) >>> COEF_FRAC_BITS;

    always_comb begin
        res_word.bin_real  = re_round[OUT_W-1:0];
        res_word.bin_imag  = im_round[OUT_W-1:0];
        res_word.bin_index = BIN_W'(p3_bin_reg);
        res_word.last_bin  = (p3_bin_reg == IDX_LAST);
    end

    always_ff @(posedge aclk) begin
        if (fill_we || wb_we) begin
            sample_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= sample_mem[k_reg];

        p1_win_reg   <= win_issue;
        p1_first_reg <= (k_reg == '0);
        p1_last_reg  <= k_last;
        p1_addr_reg  <= k_reg;
        p1_bin_reg   <= j_reg;
        coef_a_reg   <= coef_a;
        coef_b_reg   <= SIN_TAB[m_reg];

        // The cosine multiplier also applies the window during the in-place pass.
        p2_win_reg   <= p1_win_reg;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_addr_reg  <= p1_addr_reg;
        p2_bin_reg   <= p1_bin_reg;
        prod_a_reg   <= PROD_W'(mem_rdata_reg) * PROD_W'(coef_a_reg);
        prod_b_reg   <= PROD_W'(mem_rdata_reg) * PROD_W'(coef_b_reg);

        if (p2_valid_reg && !p2_win_reg) begin
            acc_re_reg <= (p2_first_reg ? '0 : acc_re_reg) + ACC_W'(prod_a_reg);
            acc_im_reg <= (p2_first_reg ? '0 : acc_im_reg) - ACC_W'(prod_b_reg);
        end
        p3_bin_reg <= p2_bin_reg;

        if (p3_push_reg) begin
            fifo_reg[wr_ptr_reg] <= res_word;
        end
    end

    assign m_valid     = (fifo_cnt_reg != '0);
    assign m_bin_real  = fifo_reg[rd_ptr_reg].bin_real;
    assign m_bin_imag  = fifo_reg[rd_ptr_reg].bin_imag;
    assign m_bin_index = fifo_reg[rd_ptr_reg].bin_index;
    assign m_last_bin  = fifo_reg[rd_ptr_reg].last_bin;

`ifndef NO_ASSERTIONS
    // A finished bin always finds room in the output buffer.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_push_reg |-> (fifo_cnt_reg != FIFO_FULL))
        else $error("result pushed into a full output buffer");

    // Buffered results are a subset of the bins committed at issue.
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= out_cnt_reg)
        else $error("output buffer holds more results than were issued");

    // The DFT never reads the store while a windowed write-back is still in flight.
    a_win_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        dft_issue |-> (!(p1_valid_reg && p1_win_reg) && !(p2_valid_reg && p2_win_reg)))
        else $error("DFT read overlaps window write-back");

    // The request that completes a frame closes the input until the frame is processed.
    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_we && fill_last) |=> !s_ready)
        else $error("input still open after the frame completed");
`endif

endmodule
